### src/gngi_pkg.sv
// Shared constants, types and helpers for the grid neighbor / ghost index block.
package gngi_pkg;

  localparam int MAX_SIDE  = 4096;
  localparam int POS_W     = $clog2(MAX_SIDE);      // x / y position width
  localparam int SIDE_W    = POS_W + 1;             // clamped side, 1..MAX_SIDE
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int IDX_W     = 24;
  localparam int NBR_W     = 25;
  localparam int DIV_W     = IDX_W + 1;             // shifted divisor / trial difference
  localparam int DIV_STEPS = POS_W;                 // quotient bits (k div side < MAX_SIDE)
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int STAGES    = DIV_STEPS + 3;         // input, divide steps, multiply, output

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;
  localparam logic [CFG_W-1:0]     SIDE_RESET  = 13'd64;

  // grid geometry derived from the two side registers
  typedef struct packed {
    logic [SIDE_W-1:0] nx;
    logic [SIDE_W-1:0] ny;
    logic [NBR_W-1:0]  total;
    logic [NBR_W-1:0]  base_s;
    logic [NBR_W-1:0]  base_e;
    logic [NBR_W-1:0]  base_w;
  } geom_t;

  // item state through the two parallel restoring dividers
  typedef struct packed {
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] rx;
    logic [POS_W-1:0] qx;
    logic [IDX_W-1:0] ry;
    logic [POS_W-1:0] qy;
  } div_t;

  function automatic logic [SIDE_W-1:0] side_clamp(input logic [CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) return SIDE_W'(1);
    if (w > 32'(MAX_SIDE)) return SIDE_W'(MAX_SIDE);
    return SIDE_W'(w);
  endfunction

endpackage

### src/grid_neighbor_ghost_index.sv
// Top level: pipelined grid neighbor and ghost cell index generator.
//
//   channel  direction  handshake              beat contents
//   in       input      in_valid / in_stall    cell_index
//   out      output     out_valid / out_stall  neighbors, transposes, x/y, index_error
//   cfg      input      cfg_write              cfg_index, cfg_data (0 columns, 1 rows)
//
// One beat per cycle sustained while out_stall is low; stages from input to output register:
// input register, 12 divide steps for k div/mod columns and rows, multiply, output.
// The divide step chain sets the depth: one quotient bit per stage.
// Reset sets columns and rows to 64 and empties the pipeline.
// A stall on the output holds the last stage; earlier stages keep filling bubbles,
// and in_stall rises only when every stage holds a beat.
module grid_neighbor_ghost_index (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [gngi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gngi_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [gngi_pkg::IDX_W-1:0]     cell_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gngi_pkg::NBR_W-1:0]     east_neighbor,
  output logic [gngi_pkg::NBR_W-1:0]     west_neighbor,
  output logic [gngi_pkg::NBR_W-1:0]     north_neighbor,
  output logic [gngi_pkg::NBR_W-1:0]     south_neighbor,
  output logic [gngi_pkg::IDX_W-1:0]     transposed_index,
  output logic [gngi_pkg::IDX_W-1:0]     reverse_transposed_index,
  output logic [gngi_pkg::POS_W-1:0]     x_position,
  output logic [gngi_pkg::POS_W-1:0]     y_position,
  output logic                           index_error
);
  import gngi_pkg::*;

  geom_t            geom;
  logic [STAGES-1:0] v;
  logic [STAGES-1:0] adv;
  logic [IDX_W-1:0]  k0;
  div_t              dstage [DIV_STEPS+1];

  gngi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    adv[STAGES-1] = !v[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      k0 <= cell_index;
    end
  end

  assign dstage[0] = '{k: k0, rx: k0, qx: '0, ry: k0, qy: '0};

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    gngi_div_step u_step (
      .clk     (clk),
      .en      (adv[s+1]),
      .bit_pos (STEP_W'(DIV_STEPS - 1 - s)),
      .nx      (geom.nx),
      .ny      (geom.ny),
      .d_in    (dstage[s]),
      .d_out   (dstage[s+1])
    );
  end

  gngi_tail u_tail (
    .clk                      (clk),
    .en_mul                   (adv[DIV_STEPS+1]),
    .en_out                   (adv[DIV_STEPS+2]),
    .geom                     (geom),
    .d_in                     (dstage[DIV_STEPS]),
    .east_neighbor            (east_neighbor),
    .west_neighbor            (west_neighbor),
    .north_neighbor           (north_neighbor),
    .south_neighbor           (south_neighbor),
    .transposed_index         (transposed_index),
    .reverse_transposed_index (reverse_transposed_index),
    .x_position               (x_position),
    .y_position               (y_position),
    .index_error              (index_error)
  );

  // input backpressure only when the whole pipe is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&v) && out_stall))
    else $error("in_stall raised with room in the pipeline");

  // an accepted beat always lands in the input stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v[0])
    else $error("accepted beat lost at the input stage");

  // out-of-range beats carry zero in every other field
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && index_error) |->
      (east_neighbor == '0 && west_neighbor == '0 && north_neighbor == '0 &&
       south_neighbor == '0 && transposed_index == '0 &&
       reverse_transposed_index == '0 && x_position == '0 && y_position == '0))
    else $error("error beat with nonzero fields");

  // a beat that leaves the last divide step moves into the multiply stage
  a_mul_fill: assert property (@(posedge clk) disable iff (rst)
    (v[DIV_STEPS] && adv[DIV_STEPS+1]) |=> v[DIV_STEPS+1])
    else $error("beat dropped between divide and multiply stages");

endmodule

### src/gngi_cfg.sv
// Side registers and the grid geometry derived from them.
module gngi_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [gngi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gngi_pkg::CFG_W-1:0]     cfg_data,
  output gngi_pkg::geom_t                geom
);
  import gngi_pkg::*;

  logic [CFG_W-1:0]  columns;
  logic [CFG_W-1:0]  rows;
  logic [SIDE_W-1:0] nx;
  logic [SIDE_W-1:0] ny;
  logic [NBR_W-1:0]  total;
  logic [NBR_W-1:0]  base_s;
  logic [NBR_W-1:0]  base_e;
  logic [NBR_W-1:0]  base_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= SIDE_RESET;
      rows    <= SIDE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLUMNS: columns <= cfg_data;
        REG_ROWS:    rows    <= cfg_data;
      endcase
    end
  end

  assign nx = side_clamp(columns);
  assign ny = side_clamp(rows);

  // ghost bases settle after a write, well before a beat needs them
  always_ff @(posedge clk) begin
    total  <= NBR_W'(nx) * NBR_W'(ny);
    base_s <= total + NBR_W'(nx);
    base_e <= total + (NBR_W'(nx) << 1);
    base_w <= base_e + NBR_W'(ny);
  end

  always_comb begin
    geom.nx     = nx;
    geom.ny     = ny;
    geom.total  = total;
    geom.base_s = base_s;
    geom.base_e = base_e;
    geom.base_w = base_w;
  end

endmodule

### src/gngi_div_step.sv
// One registered restoring-division step for both the column and row divisors.
module gngi_div_step (
  input  logic                        clk,
  input  logic                        en,
  input  logic [gngi_pkg::STEP_W-1:0] bit_pos,
  input  logic [gngi_pkg::SIDE_W-1:0] nx,
  input  logic [gngi_pkg::SIDE_W-1:0] ny,
  input  gngi_pkg::div_t              d_in,
  output gngi_pkg::div_t              d_out
);
  import gngi_pkg::*;

  logic [DIV_W-1:0] dsh_x;
  logic [DIV_W-1:0] dsh_y;
  logic [DIV_W-1:0] sub_x;
  logic [DIV_W-1:0] sub_y;
  logic             take_x;
  logic             take_y;
  div_t             d_next;

  always_comb begin
    dsh_x  = DIV_W'(nx) << bit_pos;
    dsh_y  = DIV_W'(ny) << bit_pos;
    sub_x  = {1'b0, d_in.rx} - dsh_x;
    sub_y  = {1'b0, d_in.ry} - dsh_y;
    take_x = {1'b0, d_in.rx} >= dsh_x;
    take_y = {1'b0, d_in.ry} >= dsh_y;

    d_next = d_in;
    if (take_x) begin
      d_next.rx          = sub_x[IDX_W-1:0];
      d_next.qx[bit_pos] = 1'b1;
    end
    if (take_y) begin
      d_next.ry          = sub_y[IDX_W-1:0];
      d_next.qy[bit_pos] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

### src/gngi_tail.sv
// Multiply stage and output stage: transposes, neighbors, range check.
module gngi_tail (
  input  logic                       clk,
  input  logic                       en_mul,
  input  logic                       en_out,
  input  gngi_pkg::geom_t            geom,
  input  gngi_pkg::div_t             d_in,
  output logic [gngi_pkg::NBR_W-1:0] east_neighbor,
  output logic [gngi_pkg::NBR_W-1:0] west_neighbor,
  output logic [gngi_pkg::NBR_W-1:0] north_neighbor,
  output logic [gngi_pkg::NBR_W-1:0] south_neighbor,
  output logic [gngi_pkg::IDX_W-1:0] transposed_index,
  output logic [gngi_pkg::IDX_W-1:0] reverse_transposed_index,
  output logic [gngi_pkg::POS_W-1:0] x_position,
  output logic [gngi_pkg::POS_W-1:0] y_position,
  output logic                       index_error
);
  import gngi_pkg::*;

  localparam int PROD_W = POS_W + SIDE_W;

  // multiply stage registers
  logic [IDX_W-1:0] k;
  logic [POS_W-1:0] x;
  logic [POS_W-1:0] y;
  logic [POS_W-1:0] qy;
  logic [IDX_W-1:0] prod_t;
  logic [IDX_W-1:0] prod_r;
  logic             err;
  logic             last_col;
  logic             first_col;
  logic             top_row;
  logic             bot_row;

  logic [POS_W-1:0]  x_in;
  logic [POS_W-1:0]  ry_in;
  logic [PROD_W-1:0] prod_t_full;
  logic [PROD_W-1:0] prod_r_full;

  always_comb begin
    x_in        = d_in.rx[POS_W-1:0];
    ry_in       = d_in.ry[POS_W-1:0];
    prod_t_full = PROD_W'(ry_in) * PROD_W'(geom.nx);
    prod_r_full = PROD_W'(x_in) * PROD_W'(geom.ny);
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      k         <= d_in.k;
      x         <= x_in;
      y         <= d_in.qx;
      qy        <= d_in.qy;
      prod_t    <= prod_t_full[IDX_W-1:0];
      prod_r    <= prod_r_full[IDX_W-1:0];
      err       <= {1'b0, d_in.k} >= geom.total;
      last_col  <= {1'b0, x_in} == geom.nx - SIDE_W'(1);
      first_col <= x_in == '0;
      top_row   <= {1'b0, d_in.qx} == geom.ny - SIDE_W'(1);
      bot_row   <= d_in.qx == '0;
    end
  end

  logic [NBR_W-1:0] k_w;
  logic [NBR_W-1:0] east_next;
  logic [NBR_W-1:0] west_next;
  logic [NBR_W-1:0] north_next;
  logic [NBR_W-1:0] south_next;

  always_comb begin
    k_w        = NBR_W'(k);
    east_next  = last_col  ? geom.base_e + NBR_W'(y) : k_w + NBR_W'(1);
    west_next  = first_col ? geom.base_w + NBR_W'(y) : k_w - NBR_W'(1);
    north_next = top_row   ? geom.total  + NBR_W'(x) : k_w + NBR_W'(geom.nx);
    south_next = bot_row   ? geom.base_s + NBR_W'(x) : k_w - NBR_W'(geom.nx);
  end

  // out-of-range beats carry only the error flag
  always_ff @(posedge clk) begin
    if (en_out) begin
      index_error <= err;
      if (err) begin
        east_neighbor            <= '0;
        west_neighbor            <= '0;
        north_neighbor           <= '0;
        south_neighbor           <= '0;
        transposed_index         <= '0;
        reverse_transposed_index <= '0;
        x_position               <= '0;
        y_position               <= '0;
      end else begin
        east_neighbor            <= east_next;
        west_neighbor            <= west_next;
        north_neighbor           <= north_next;
        south_neighbor           <= south_next;
        transposed_index         <= prod_t + IDX_W'(qy);
        reverse_transposed_index <= prod_r + IDX_W'(y);
        x_position               <= x;
        y_position               <= y;
      end
    end
  end

endmodule

### tb/tb.sv
// Testbench for the grid neighbor / ghost index block: directed corners, then random grids.
`timescale 1ns / 1ps

module tb;
  import gngi_pkg::*;

  localparam int LATENCY = STAGES;

  typedef struct packed {
    logic [NBR_W-1:0] east;
    logic [NBR_W-1:0] west;
    logic [NBR_W-1:0] north;
    logic [NBR_W-1:0] south;
    logic [IDX_W-1:0] trans;
    logic [IDX_W-1:0] rtrans;
    logic [POS_W-1:0] xpos;
    logic [POS_W-1:0] ypos;
    logic             err;
  } cell_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [IDX_W-1:0]     cell_index;
  logic                 out_valid;
  logic                 out_stall;
  logic [NBR_W-1:0]     east_neighbor;
  logic [NBR_W-1:0]     west_neighbor;
  logic [NBR_W-1:0]     north_neighbor;
  logic [NBR_W-1:0]     south_neighbor;
  logic [IDX_W-1:0]     transposed_index;
  logic [IDX_W-1:0]     reverse_transposed_index;
  logic [POS_W-1:0]     x_position;
  logic [POS_W-1:0]     y_position;
  logic                 index_error;

  // shadow of the two side registers as written
  logic [CFG_W-1:0] grid_columns;
  logic [CFG_W-1:0] grid_rows;

  cell_result_t expected_cells[$];
  int           mismatches;
  int           stall_left;
  bit           no_gaps;

  grid_neighbor_ghost_index uut (
    .clk                      (clk),
    .rst                      (rst),
    .cfg_write                (cfg_write),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .cell_index               (cell_index),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .east_neighbor            (east_neighbor),
    .west_neighbor            (west_neighbor),
    .north_neighbor           (north_neighbor),
    .south_neighbor           (south_neighbor),
    .transposed_index         (transposed_index),
    .reverse_transposed_index (reverse_transposed_index),
    .x_position               (x_position),
    .y_position               (y_position),
    .index_error              (index_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // 0 acts as 1, anything past MAX_SIDE acts as MAX_SIDE
  function automatic longint unsigned limit_side(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE) return 64'(MAX_SIDE);
    return 64'(v);
  endfunction

  function automatic cell_result_t predict_neighbors(input logic [IDX_W-1:0] k);
    longint unsigned nx, ny, total, kk, x, y;
    cell_result_t r;
    nx    = limit_side(grid_columns);
    ny    = limit_side(grid_rows);
    total = nx * ny;
    kk    = 64'(k);
    r     = '0;
    if (kk >= total) begin
      r.err = 1'b1;
      return r;
    end
    x = kk % nx;
    y = kk / nx;
    // ghost blocks follow the interior: north, south, east, west
    r.east   = (x == nx - 1) ? NBR_W'(total + 2 * nx + y) : NBR_W'(kk + 1);
    r.west   = (x == 0) ? NBR_W'(total + 2 * nx + ny + y) : NBR_W'(kk - 1);
    r.north  = (y == ny - 1) ? NBR_W'(total + x) : NBR_W'(kk + nx);
    r.south  = (y == 0) ? NBR_W'(total + nx + x) : NBR_W'(kk - nx);
    r.trans  = IDX_W'((kk % ny) * nx + kk / ny);
    r.rtrans = IDX_W'(x * ny + y);
    r.xpos   = POS_W'(x);
    r.ypos   = POS_W'(y);
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] draw_side();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'(MAX_SIDE);
      3:       return CFG_W'($urandom_range(8191, MAX_SIDE + 1));
      4:       return CFG_W'(8191);
      5, 6:    return CFG_W'($urandom_range(16, 2));
      default: return CFG_W'($urandom_range(MAX_SIDE, 1));
    endcase
  endfunction

  // mostly in-grid cells biased to the borders, some past the end, some raw
  function automatic logic [IDX_W-1:0] draw_cell();
    longint unsigned nx, ny, total, x, y;
    int sel;
    nx    = limit_side(grid_columns);
    ny    = limit_side(grid_rows);
    total = nx * ny;
    sel   = $urandom_range(0, 9);
    if (sel == 0) return IDX_W'($urandom);
    if (sel == 1 && total < 64'h1000000)
      return IDX_W'($urandom_range(32'hFFFFFF, 32'(total)));
    case ($urandom_range(0, 3))
      0:       x = 0;
      1:       x = nx - 1;
      default: x = 64'($urandom_range(32'(nx - 1), 0));
    endcase
    case ($urandom_range(0, 3))
      0:       y = 0;
      1:       y = ny - 1;
      default: y = 64'($urandom_range(32'(ny - 1), 0));
    endcase
    return IDX_W'(y * nx + x);
  endfunction

  // every stimulus task below starts and ends at a falling edge with nothing yet driven there
  task automatic send_cell(input logic [IDX_W-1:0] k);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    cell_index <= k;
    expected_cells.push_back(predict_neighbors(k));
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_cells.size() != 0) @(negedge clk);
  endtask

  task automatic set_grid(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] nrows);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data  <= cols;
    @(negedge clk);
    cfg_index <= REG_ROWS;
    cfg_data  <= nrows;
    @(negedge clk);
    cfg_write    <= 1'b0;
    grid_columns = cols;
    grid_rows    = nrows;
    @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    send_cell(24'd0);
    send_cell(24'd63);
    send_cell(24'd64);
    send_cell(24'd4095);
    send_cell(24'd4096);
    send_cell(24'hFFFFFF);
  endtask

  task automatic test_degenerate_grids();
    set_grid('0, '0);                 // both sides act as one cell
    send_cell(24'd0);
    send_cell(24'd1);
    set_grid(CFG_W'(1), CFG_W'(5));   // single column
    send_cell(24'd0);
    send_cell(24'd2);
    send_cell(24'd4);
    send_cell(24'd5);
    set_grid(CFG_W'(7), CFG_W'(1));   // single row
    send_cell(24'd0);
    send_cell(24'd6);
    send_cell(24'd7);
    set_grid(CFG_W'(8191), CFG_W'(4097));  // saturates to the full 4096 x 4096 grid
    send_cell(24'd0);
    send_cell(24'd4095);
    send_cell(24'hFFF000);
    send_cell(24'hFFFFFF);
    set_grid(CFG_W'(MAX_SIDE), CFG_W'(3));
    send_cell(24'd12287);
    send_cell(24'd12288);
  endtask

  task automatic test_random_grids();
    int sent, count, i, phase;
    sent  = 0;
    phase = 0;
    while (sent < 1350) begin
      if (phase % 5 == 4)
        set_grid(CFG_W'(MAX_SIDE), CFG_W'($urandom_range(8191, MAX_SIDE)));
      else
        set_grid(draw_side(), draw_side());
      no_gaps = ($urandom_range(0, 3) == 0);
      count   = $urandom_range(120, 20);
      for (i = 0; i < count; i++) send_cell(draw_cell());
      sent += count;
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [NBR_W-1:0] want,
                             input logic [NBR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cell_result_t exp_cell;
    if (!rst && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: result beat with none expected, expected nothing got east %0d",
                 $time, east_neighbor);
        mismatches++;
      end else begin
        exp_cell = expected_cells.pop_front();
        check_field("east_neighbor", exp_cell.east, east_neighbor);
        check_field("west_neighbor", exp_cell.west, west_neighbor);
        check_field("north_neighbor", exp_cell.north, north_neighbor);
        check_field("south_neighbor", exp_cell.south, south_neighbor);
        check_field("transposed_index", NBR_W'(exp_cell.trans),
                    NBR_W'(transposed_index));
        check_field("reverse_transposed_index", NBR_W'(exp_cell.rtrans),
                    NBR_W'(reverse_transposed_index));
        check_field("x_position", NBR_W'(exp_cell.xpos), NBR_W'(x_position));
        check_field("y_position", NBR_W'(exp_cell.ypos), NBR_W'(y_position));
        check_field("index_error", NBR_W'(exp_cell.err), NBR_W'(index_error));
      end
      stall_left = no_gaps ? 0 : $urandom_range(0, 9);
    end
  end

  // receiver holds off for the drawn number of cycles after each beat
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_COLUMNS;
    cfg_data     = '0;
    in_valid     = 1'b0;
    cell_index   = '0;
    out_stall    = 1'b0;
    stall_left   = 0;
    no_gaps      = 1'b0;
    mismatches   = 0;
    grid_columns = SIDE_RESET;
    grid_rows    = SIDE_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_degenerate_grids();
    test_random_grids();
    drain();
    repeat (LATENCY + 5) @(negedge clk);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/gngi_pkg.sv
src/gngi_cfg.sv
src/gngi_div_step.sv
src/gngi_tail.sv
src/grid_neighbor_ghost_index.sv
tb/tb.sv
